### rtl/imu_gesture_window_classifier_macros.svh
// Assertion macros shared by the gesture classifier checker.
`ifndef IMU_GESTURE_WINDOW_CLASSIFIER_MACROS_SVH
`define IMU_GESTURE_WINDOW_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IGWC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("igwc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IGWC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("igwc assertion failed");

`endif

### rtl/igwc_pkg.sv
// Shared types, codes and constants of the IMU gesture window classifier.
package igwc_pkg;

    localparam int WINDOW_LEN_DEF = 5;
    localparam int PADDR_W        = 5;

    localparam int unsigned THROW_MIN_LOW  = 3;
    localparam int unsigned TWIST_MIN_ROT  = 2;
    localparam int unsigned SHAKE_MIN_HIGH = 2;

    typedef enum logic [1:0] {
        CLS_QUIET = 2'd0,
        CLS_LOW   = 2'd1,
        CLS_HIGH  = 2'd2,
        CLS_ROT   = 2'd3
    } class_t;

    typedef enum logic [1:0] {
        GEST_NONE  = 2'd0,
        GEST_THROW = 2'd1,
        GEST_TWIST = 2'd2,
        GEST_SHAKE = 2'd3
    } gesture_t;

    typedef enum logic [2:0] {
        REG_LOW_MAG   = 3'd0,
        REG_HIGH_MAG  = 3'd1,
        REG_ROT_LIMIT = 3'd2,
        REG_ONE_G     = 3'd3,
        REG_LEVEL_TOL = 3'd4,
        REG_HOLDOFF   = 3'd5
    } reg_idx_t;

    localparam logic [31:0] LOW_MAG_RST   = 32'd26843546;
    localparam logic [31:0] HIGH_MAG_RST  = 32'd805306368;
    localparam logic [15:0] ROT_LIMIT_RST = 16'd3608;
    localparam logic [14:0] ONE_G_RST     = 15'd16384;
    localparam logic [14:0] LEVEL_TOL_RST = 15'd2458;
    localparam logic [15:0] HOLDOFF_RST   = 16'd1000;

    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        logic [15:0] r;
        r = v[15] ? 16'(-v) : 16'(v);
        return r;
    endfunction

endpackage

### rtl/igwc_sqacc.sv
// Shared squaring accumulator: adds the square of one axis per enabled cycle.
module igwc_sqacc (
    input  logic               aclk,
    input  logic               clear,
    input  logic               en,
    input  logic signed [15:0] operand,
    output logic [31:0]        acc
);

    logic [15:0] mag;
    logic [31:0] prod;
    logic [31:0] acc_reg;

    assign mag  = igwc_pkg::mag16(operand);
    assign prod = mag * mag;
    assign acc  = acc_reg;

    // three squares of 16-bit magnitudes stay below 2^32
    always_ff @(posedge aclk) begin
        if (clear) begin
            acc_reg <= '0;
        end else if (en) begin
            acc_reg <= acc_reg + prod;
        end
    end

endmodule

### rtl/imu_gesture_window_classifier.sv
// One sample at a time: s_ready is high only while idle, so no new sample is
// taken until the last result has loaded the output register.
// Each sample passes the shared squarer (one axis at a time) and then
// the histogram pass, which visits one window entry per cycle.
// Reset (synchronous, aresetn low): registers to defaults, window quiet,
// write slot and last detection time zero, no result pending.
module imu_gesture_window_classifier #(
    parameter int WINDOW_LEN = igwc_pkg::WINDOW_LEN_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [15:0]          s_accel_x,
    input  logic signed [15:0]          s_accel_y,
    input  logic signed [15:0]          s_accel_z,
    input  logic signed [15:0]          s_rate_x,
    input  logic signed [15:0]          s_rate_y,
    input  logic signed [15:0]          s_rate_z,
    input  logic [31:0]                 s_time_ms,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_gesture,
    output logic [1:0]                  m_sample_class,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [igwc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IDX_W = $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_CLS,
        ST_CNT,
        ST_DEC
    } state_t;

    // configuration
    logic [31:0] low_mag_reg;
    logic [31:0] high_mag_reg;
    logic [15:0] rot_limit_reg;
    logic [14:0] one_g_reg;
    logic [14:0] level_tol_reg;
    logic [15:0] holdoff_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    state_t                  state_reg;
    logic [1:0]              sq_cnt_reg;
    logic signed [15:0]      ax_reg, ay_reg, az_reg;
    logic [15:0]             gx_reg, gy_reg, gz_reg;
    logic [31:0]             time_reg;
    logic [1:0]              window_reg [WINDOW_LEN];
    logic [IDX_W-1:0]        slot_reg;
    logic [IDX_W-1:0]        slot_next;
    logic [IDX_W-1:0]        idx_reg;
    logic [CNT_W-1:0]        cnt_low_reg, cnt_high_reg, cnt_rot_reg;
    logic [1:0]              oldest_reg;
    igwc_pkg::class_t        cls_reg;
    logic [31:0]             last_det_reg;
    logic                    m_valid_reg;
    logic [1:0]              m_gesture_reg;
    logic [1:0]              m_class_reg;

    logic                    accept;
    logic signed [15:0]      sq_operand;
    logic [31:0]             mag_sum;
    igwc_pkg::class_t        cls_now;
    logic [1:0]              entry;
    logic [31:0]             elapsed;
    logic [15:0]             az_mag;
    logic signed [16:0]      dev;
    logic [16:0]             adev;
    igwc_pkg::gesture_t      gest;
    logic                    out_free;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[igwc_pkg::PADDR_W-1:2];

    always_comb begin
        case (cfg_idx)
            igwc_pkg::REG_LOW_MAG:   prdata = low_mag_reg;
            igwc_pkg::REG_HIGH_MAG:  prdata = high_mag_reg;
            igwc_pkg::REG_ROT_LIMIT: prdata = {16'd0, rot_limit_reg};
            igwc_pkg::REG_ONE_G:     prdata = {17'd0, one_g_reg};
            igwc_pkg::REG_LEVEL_TOL: prdata = {17'd0, level_tol_reg};
            igwc_pkg::REG_HOLDOFF:   prdata = {16'd0, holdoff_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_mag_reg   <= igwc_pkg::LOW_MAG_RST;
            high_mag_reg  <= igwc_pkg::HIGH_MAG_RST;
            rot_limit_reg <= igwc_pkg::ROT_LIMIT_RST;
            one_g_reg     <= igwc_pkg::ONE_G_RST;
            level_tol_reg <= igwc_pkg::LEVEL_TOL_RST;
            holdoff_reg   <= igwc_pkg::HOLDOFF_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                igwc_pkg::REG_LOW_MAG:   low_mag_reg   <= pwdata;
                igwc_pkg::REG_HIGH_MAG:  high_mag_reg  <= pwdata;
                igwc_pkg::REG_ROT_LIMIT: rot_limit_reg <= pwdata[15:0];
                igwc_pkg::REG_ONE_G:     one_g_reg     <= pwdata[14:0];
                igwc_pkg::REG_LEVEL_TOL: level_tol_reg <= pwdata[14:0];
                igwc_pkg::REG_HOLDOFF:   holdoff_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign accept         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_gesture      = m_gesture_reg;
    assign m_sample_class = m_class_reg;
    assign out_free       = !m_valid_reg || m_ready;

    always_comb begin
        case (sq_cnt_reg)
            2'd0:    sq_operand = ax_reg;
            2'd1:    sq_operand = ay_reg;
            default: sq_operand = az_reg;
        endcase
    end

    igwc_sqacc u_sqacc (
        .aclk    (aclk),
        .clear   (accept),
        .en      (state_reg == ST_SQ),
        .operand (sq_operand),
        .acc     (mag_sum)
    );

    always_comb begin
        if (mag_sum < low_mag_reg) begin
            cls_now = igwc_pkg::CLS_LOW;
        end else if (mag_sum > high_mag_reg) begin
            cls_now = igwc_pkg::CLS_HIGH;
        end else if (gx_reg > rot_limit_reg || gy_reg > rot_limit_reg ||
                     gz_reg > rot_limit_reg) begin
            cls_now = igwc_pkg::CLS_ROT;
        end else begin
            cls_now = igwc_pkg::CLS_QUIET;
        end
    end

    assign slot_next = (slot_reg == IDX_W'(WINDOW_LEN - 1)) ? '0 : slot_reg + 1'b1;
    assign entry     = window_reg[idx_reg];

    // decision rules, later rule wins
    assign elapsed = time_reg - last_det_reg;
    assign az_mag  = igwc_pkg::mag16(az_reg);
    assign dev     = $signed({1'b0, az_mag}) - $signed({2'b00, one_g_reg});
    assign adev    = dev[16] ? 17'(-dev) : 17'(dev);

    always_comb begin
        gest = igwc_pkg::GEST_NONE;
        if (elapsed > {16'd0, holdoff_reg}) begin
            if (oldest_reg == igwc_pkg::CLS_LOW &&
                32'(cnt_low_reg) >= igwc_pkg::THROW_MIN_LOW) begin
                gest = igwc_pkg::GEST_THROW;
            end
            if (oldest_reg == igwc_pkg::CLS_ROT &&
                32'(cnt_rot_reg) >= igwc_pkg::TWIST_MIN_ROT &&
                cnt_low_reg == '0 && cnt_high_reg == '0 &&
                adev < {2'b00, level_tol_reg}) begin
                gest = igwc_pkg::GEST_TWIST;
            end
            if (oldest_reg == igwc_pkg::CLS_HIGH &&
                32'(cnt_high_reg) >= igwc_pkg::SHAKE_MIN_HIGH &&
                cnt_low_reg == '0) begin
                gest = igwc_pkg::GEST_SHAKE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sq_cnt_reg   <= '0;
            slot_reg     <= '0;
            idx_reg      <= '0;
            last_det_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                window_reg[i] <= igwc_pkg::CLS_QUIET;
            end
        end else begin
            // a new result loads the output register, else a taken one frees it
            if (state_reg == ST_DEC && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        ax_reg     <= s_accel_x;
                        ay_reg     <= s_accel_y;
                        az_reg     <= s_accel_z;
                        gx_reg     <= igwc_pkg::mag16(s_rate_x);
                        gy_reg     <= igwc_pkg::mag16(s_rate_y);
                        gz_reg     <= igwc_pkg::mag16(s_rate_z);
                        time_reg   <= s_time_ms;
                        sq_cnt_reg <= '0;
                        state_reg  <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == 2'd2) begin
                        state_reg <= ST_CLS;
                    end
                end
                ST_CLS: begin
                    window_reg[slot_reg] <= cls_now;
                    cls_reg      <= cls_now;
                    slot_reg     <= slot_next;
                    idx_reg      <= '0;
                    cnt_low_reg  <= '0;
                    cnt_high_reg <= '0;
                    cnt_rot_reg  <= '0;
                    state_reg    <= ST_CNT;
                end
                ST_CNT: begin
                    case (entry)
                        igwc_pkg::CLS_LOW:  cnt_low_reg  <= cnt_low_reg + 1'b1;
                        igwc_pkg::CLS_HIGH: cnt_high_reg <= cnt_high_reg + 1'b1;
                        igwc_pkg::CLS_ROT:  cnt_rot_reg  <= cnt_rot_reg + 1'b1;
                        default: ;
                    endcase
                    // the slot after the new write holds the oldest class
                    if (idx_reg == slot_reg) begin
                        oldest_reg <= entry;
                    end
                    if (idx_reg == IDX_W'(WINDOW_LEN - 1)) begin
                        state_reg <= ST_DEC;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DEC: begin
                    if (out_free) begin
                        m_gesture_reg <= gest;
                        m_class_reg   <= cls_reg;
                        if (gest != igwc_pkg::GEST_NONE) begin
                            last_det_reg <= time_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/igwc_checker.sv
// Port-level checker for the gesture classifier, bound to the top level.
`include "imu_gesture_window_classifier_macros.svh"

module igwc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_gesture,
    input logic [1:0] m_sample_class
);

    // a stalled result holds
    `IGWC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_gesture) && $stable(m_sample_class))

    // one sample at a time: no request taken right after another
    `IGWC_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)

    // shake needs a window without free fall, so this sample is not low
    `IGWC_ASSERT_IMP(a_shake_class, aclk, aresetn,
        m_valid && m_gesture == igwc_pkg::GEST_SHAKE,
        m_sample_class != igwc_pkg::CLS_LOW)

    // twist needs a window free of low and very high samples
    `IGWC_ASSERT_IMP(a_twist_class, aclk, aresetn,
        m_valid && m_gesture == igwc_pkg::GEST_TWIST,
        m_sample_class == igwc_pkg::CLS_ROT || m_sample_class == igwc_pkg::CLS_QUIET)

endmodule

bind imu_gesture_window_classifier igwc_checker u_igwc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_gesture      (m_gesture),
    .m_sample_class (m_sample_class)
);
